// ===== design/mt64_pkg.sv =====
// ----------------------------------------------------------------------------
// mt64_pkg
// constants and shared types for the 64-bit twisted gfsr generator
// ----------------------------------------------------------------------------
package mt64_pkg;

  localparam int unsigned NWORDS     = 9;
  localparam int unsigned KW         = 4;   // width of the seeding chain step counter

  localparam logic [63:0] MAT_A       = 64'h81f1fd68012348bc;
  localparam logic [63:0] TEMPER_MASK = 64'h66edc62a6bf8c826;
  localparam logic [63:0] SEED_MUL    = 64'd6364136223846793005;

  localparam int unsigned SPLIT      = 33;  // lower bits taken from word i+1
  localparam int unsigned SH_CHAIN   = 62;
  localparam int unsigned SH_EXTRA_L = 13;
  localparam int unsigned SH_EXTRA_R = 35;
  localparam int unsigned SH_TEMPER  = 30;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic en;    // update the accumulator
    logic load;  // acc = a*b + addend, else acc += (a*b) << 32
  } mac_ctl_t;

endpackage

// ===== design/mt64_mac.sv =====
// ----------------------------------------------------------------------------
// mt64_mac
// shared 32x32 multiplier with a 64-bit accumulator for the seeding chain
// ----------------------------------------------------------------------------
module mt64_mac (
  input  logic              clk,
  input  mt64_pkg::mac_ctl_t ctl,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [63:0]       addend,
  output logic [63:0]       acc
);

  logic [63:0] prod;
  logic [63:0] acc_next;

  assign prod = {32'b0, a} * {32'b0, b};

  always_comb begin
    if (ctl.load) begin
      acc_next = prod + addend;
    end else begin
      // only the low half of a cross product lands in the low 64 bits
      acc_next = acc + {prod[31:0], 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== design/twisted_gfsr_64bit_random_generator.sv =====
// ----------------------------------------------------------------------------
// twisted_gfsr_64bit_random_generator
// 64-bit twisted gfsr generator: nine state words, one extra word, tempering
// ----------------------------------------------------------------------------
//
//   channel   signals                          direction   word
//   input     in_valid in_stall func seed_value in          request
//   output    out_valid out_stall random_word   out         tempered word
//
// for a generate word the twist and tempering are xor and shift logic on
// fixed taps of a rotating ring of the nine state words.
// a seed word runs eight chain words and the extra word, each through the
// single shared 32x32 multiplier (three partial products, then the result
// is taken).
// reset clears the ring, the extra word and all control; no clearing pass.
// the input stalls while seeding and while a finished word waits on a stalled
// output register; a seed word gives no output word.
module twisted_gfsr_64bit_random_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [63:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_word
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEED = 1'b1;

  localparam logic [1:0] PH_LL   = 2'd0;  // v_lo * m_lo + k
  localparam logic [1:0] PH_LH   = 2'd1;  // + (v_lo * m_hi) << 32
  localparam logic [1:0] PH_HL   = 2'd2;  // + (v_hi * m_lo) << 32
  localparam logic [1:0] PH_TAKE = 2'd3;  // chain word ready in acc

  localparam logic [mt64_pkg::KW-1:0] K_LAST = mt64_pkg::KW'(mt64_pkg::NWORDS);

  // ring position p holds state word (index + p) mod 9, so taps are fixed
  logic [63:0] ring [mt64_pkg::NWORDS];
  logic [63:0] extra;
  logic        state;
  logic [1:0]  phase;
  logic [mt64_pkg::KW-1:0] k;

  logic        in_accept;
  logic        out_accept;
  logic        gen_accept;
  logic        seed_accept;
  logic        shift_en;
  logic [63:0] shift_word;

  // twist and temper
  logic [63:0] x;
  logic [63:0] extra_next;
  logic [63:0] w;
  logic [63:0] temper;

  // seeding chain
  logic [63:0]        v;
  logic [31:0]        mac_a;
  logic [31:0]        mac_b;
  logic [63:0]        acc;
  mt64_pkg::mac_ctl_t mac_ctl;

  assign in_stall    = (state == ST_SEED) || (out_valid && out_stall);
  assign in_accept   = in_valid && !in_stall;
  assign out_accept  = out_valid && !out_stall;
  assign gen_accept  = in_accept && func;
  assign seed_accept = in_accept && !func;

  // upper 31 bits of word i with lower 33 bits of word i+1
  assign x = {ring[0][63:mt64_pkg::SPLIT], ring[1][mt64_pkg::SPLIT-1:0]};

  assign extra_next = (x >> 1) ^ (x[0] ? mt64_pkg::MAT_A : 64'd0) ^ ring[5]
                    ^ extra ^ (extra << mt64_pkg::SH_EXTRA_L);
  assign w      = x ^ extra_next ^ (extra_next >> mt64_pkg::SH_EXTRA_R);
  assign temper = w ^ (w << mt64_pkg::SH_TEMPER) ^ (ring[3] & mt64_pkg::TEMPER_MASK);

  // previous chain word always sits at the ring tail
  assign v = ring[mt64_pkg::NWORDS-1] ^ (ring[mt64_pkg::NWORDS-1] >> mt64_pkg::SH_CHAIN);

  always_comb begin
    mac_ctl.en   = (state == ST_SEED) && (phase != PH_TAKE);
    mac_ctl.load = (phase == PH_LL);
    case (phase)
      PH_LL: begin
        mac_a = v[31:0];
        mac_b = mt64_pkg::SEED_MUL[31:0];
      end
      PH_LH: begin
        mac_a = v[31:0];
        mac_b = mt64_pkg::SEED_MUL[63:32];
      end
      PH_HL: begin
        mac_a = v[63:32];
        mac_b = mt64_pkg::SEED_MUL[31:0];
      end
      default: begin
        mac_a = v[31:0];
        mac_b = mt64_pkg::SEED_MUL[31:0];
      end
    endcase
  end

  mt64_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (mac_a),
    .b      (mac_b),
    .addend ({{(64-mt64_pkg::KW){1'b0}}, k}),
    .acc    (acc)
  );

  // ring shift: new word enters at the tail, index advances by one
  always_comb begin
    shift_en   = 1'b0;
    shift_word = w;
    if (gen_accept) begin
      shift_en   = 1'b1;
      shift_word = w;
    end else if (seed_accept) begin
      shift_en   = 1'b1;
      shift_word = seed_value;
    end else if ((state == ST_SEED) && (phase == PH_TAKE) && (k != K_LAST)) begin
      shift_en   = 1'b1;
      shift_word = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < mt64_pkg::NWORDS; p++) begin
        ring[p] <= 64'd0;
      end
    end else if (shift_en) begin
      for (int p = 0; p < mt64_pkg::NWORDS - 1; p++) begin
        ring[p] <= ring[p+1];
      end
      ring[mt64_pkg::NWORDS-1] <= shift_word;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_LL;
      k     <= '0;
      extra <= 64'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (gen_accept) begin
            extra <= extra_next;
          end else if (seed_accept) begin
            state <= ST_SEED;
            phase <= PH_LL;
            k     <= mt64_pkg::KW'(1);
          end
        end
        ST_SEED: begin
          phase <= phase + 2'd1;
          if (phase == PH_TAKE) begin
            if (k == K_LAST) begin
              // ninth chain value becomes the extra word
              extra <= acc;
              state <= ST_IDLE;
            end
            k <= k + mt64_pkg::KW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen_accept) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_accept) begin
      random_word <= temper;
    end
  end

  // checks
  a_seed_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED) |-> in_stall)
    else $error("input taken while seeding");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED) |-> (k != '0) && (k <= K_LAST))
    else $error("seed step counter out of range");

  a_out_from_gen: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(gen_accept))
    else $error("output word without a generate request");

  a_no_mac_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mac_ctl.en)
    else $error("multiplier active while idle");

endmodule
